// File: sv/sstf_pkg.sv
package sstf_pkg;

	// Table geometry and fixed-point format
	localparam int ROWS      = 512;
	localparam int COLS      = 512;
	localparam int FRAC_BITS = 12;

	// Fixed widths of the request and result fields
	localparam int COORD_W = 10;
	localparam int QROW_W  = 9;
	localparam int TYPE_W  = 2;

	// Derived widths
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BND_W   = ($clog2(COLS + 1) > COORD_W) ? $clog2(COLS + 1) : COORD_W;
	localparam int NUM_W   = COORD_W + FRAC_BITS;      // dividend |dx| << FRAC_BITS
	localparam int SLOPE_W = COORD_W + FRAC_BITS;      // signed Q10.FRAC_BITS
	localparam int WX_W    = COORD_W + 1 + FRAC_BITS;  // signed Q11.FRAC_BITS
	localparam int DIV_CW  = $clog2(NUM_W);

	// Slope saturation limits, as magnitudes
	localparam logic [NUM_W-1:0] POS_LIM = {1'b0, {(NUM_W - 1){1'b1}}};
	localparam logic [NUM_W-1:0] NEG_LIM = {1'b1, {(NUM_W - 1){1'b0}}};

	// Request codes
	localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_EDGE  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0]  req_type;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [QROW_W-1:0]  query_row;
	} req_t;

	typedef struct packed {
		logic [QROW_W-1:0]  row_index;
		logic [COORD_W-1:0] span_left;
		logic [COORD_W-1:0] span_right;
		logic               span_nonempty;
	} res_t;

	// One table entry: left and right bound of a row
	typedef struct packed {
		logic [BND_W-1:0] left;
		logic [BND_W-1:0] right;
	} ent_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic div_step;
		logic slope_load;
		logic walk_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic flat;
		logic clr_last;
		logic div_last;
		logic walk_last;
	} sts_t;

endpackage

// File: sv/sstf_ctrl.sv
module sstf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sstf_pkg::TYPE_W-1:0] req_type,
	input  sstf_pkg::sts_t             sts,
	output sstf_pkg::cmd_t             cmd,
	output logic                       busy,
	output logic                       done
);
	import sstf_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLR   = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_SLOPE = 9'b000010000,
		S_WALK  = 9'b000100000,
		S_DRAIN = 9'b001000000,
		S_QRD   = 9'b010000000,
		S_QOUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (req_type)
						REQ_CLEAR: state_d = S_CLR;
						REQ_EDGE:  state_d = S_SETUP;
						REQ_QUERY: state_d = S_QRD;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLR:   if (sts.clr_last) state_d = S_IDLE;
			S_SETUP: state_d = sts.flat ? S_IDLE : S_DIV;
			S_DIV:   if (sts.div_last) state_d = S_SLOPE;
			S_SLOPE: state_d = S_WALK;
			S_WALK:  if (sts.walk_last) state_d = S_DRAIN;
			S_DRAIN: state_d = S_IDLE;
			S_QRD:   state_d = S_QOUT;
			S_QOUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Run the clearing pass straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

	// Commands and handshake
	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && start;
		cmd.clr_step   = (state_q == S_CLR);
		cmd.div_step   = (state_q == S_DIV);
		cmd.slope_load = (state_q == S_SLOPE);
		cmd.walk_step  = (state_q == S_WALK);
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_QOUT);

endmodule

// File: sv/sstf_dp.sv
module sstf_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  sstf_pkg::req_t req,
	input  sstf_pkg::cmd_t cmd,
	output sstf_pkg::sts_t sts,
	output sstf_pkg::res_t res
);
	import sstf_pkg::*;

	// Span tables, one entry per row
	ent_t mem [ROWS];
	ent_t rd_q;

	// Latched request
	logic [COORD_W-1:0] xa_q, ya_q, yb_q, dy_q;
	logic               neg_q, flat_q;
	logic [QROW_W-1:0]  qrow_q;

	// Divider, clear counter
	logic [COORD_W-1:0] rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DIV_CW-1:0]  div_cnt_q;
	logic [ROW_AW-1:0]  clr_cnt_q;

	// Walk
	logic signed [SLOPE_W-1:0] slope_q;
	logic signed [WX_W-1:0]    walk_x_q;
	logic [COORD_W-1:0]        row_q;

	// Write stage of the walk
	logic                 en_s1;
	logic [ROW_AW-1:0]    addr_s1;
	logic [WX_W-1:0]      x_s1;

	// Order endpoints by y
	logic               swap;
	logic [COORD_W-1:0] in_xa, in_ya, in_xb, in_yb;
	logic [COORD_W:0]   in_dx;
	logic [COORD_W-1:0] in_mag;

	always_comb begin
		swap   = req.end_y < req.start_y;
		in_xa  = swap ? req.end_x   : req.start_x;
		in_ya  = swap ? req.end_y   : req.start_y;
		in_xb  = swap ? req.start_x : req.end_x;
		in_yb  = swap ? req.start_y : req.end_y;
		in_dx  = {1'b0, in_xb} - {1'b0, in_xa};
		in_mag = in_dx[COORD_W] ? COORD_W'(-in_dx) : in_dx[COORD_W-1:0];
	end

	// Latch the word at accept
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			xa_q   <= in_xa;
			ya_q   <= in_ya;
			yb_q   <= in_yb;
			dy_q   <= in_yb - in_ya;
			neg_q  <= in_dx[COORD_W];
			flat_q <= (in_ya == in_yb);
			qrow_q <= req.query_row;
		end
	end

	// One quotient bit per cycle, restoring
	logic [COORD_W:0]   div_sh;
	logic [COORD_W+1:0] div_tr;

	always_comb begin
		div_sh = {rem_q, quo_q[NUM_W-1]};
		div_tr = {1'b0, div_sh} - {2'b00, dy_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rem_q <= '0;
			quo_q <= {in_mag, {FRAC_BITS{1'b0}}};
		end else if (cmd.div_step) begin
			if (!div_tr[COORD_W+1]) begin
				rem_q <= div_tr[COORD_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= div_sh[COORD_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// Step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.accept)        div_cnt_q <= '0;
			else if (cmd.div_step) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.accept)        clr_cnt_q <= '0;
			else if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Sign and saturate the slope
	logic signed [SLOPE_W-1:0] slope_d;

	always_comb begin
		if (!neg_q) begin
			slope_d = (quo_q > POS_LIM) ? $signed(POS_LIM) : $signed(quo_q);
		end else begin
			slope_d = (quo_q > NEG_LIM) ? $signed(NEG_LIM) : $signed(~quo_q + 1'b1);
		end
	end

	// Advance the running x and row
	logic in_rng;
	assign in_rng = ({1'b0, row_q} < ROWS);

	always_ff @(posedge clk) begin
		if (cmd.slope_load) begin
			slope_q  <= slope_d;
			walk_x_q <= $signed({1'b0, xa_q, {FRAC_BITS{1'b0}}});
			row_q    <= ya_q;
		end else if (cmd.walk_step) begin
			walk_x_q <= walk_x_q + {{(WX_W - SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
			row_q    <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) en_s1 <= 1'b0;
		else         en_s1 <= cmd.walk_step && in_rng;
	end

	always_ff @(posedge clk) begin
		addr_s1 <= ROW_AW'(row_q);
		x_s1    <= walk_x_q;
	end

	// Widen the bounds of the row read last cycle
	logic [COORD_W-1:0] fl;
	logic               frac_nz;
	ent_t               upd;

	always_comb begin
		fl      = x_s1[WX_W-2:FRAC_BITS];
		frac_nz = |x_s1[FRAC_BITS-1:0];
		upd     = rd_q;
		if (fl < rd_q.left) upd.left = BND_W'(fl);
		if ((fl > rd_q.right) || ((fl == rd_q.right) && frac_nz)) upd.right = BND_W'(fl);
	end

	// Table port: one write, one registered read
	logic              we;
	logic [ROW_AW-1:0] waddr, raddr;
	ent_t              wdata;

	always_comb begin
		we    = en_s1 || cmd.clr_step;
		waddr = en_s1 ? addr_s1 : clr_cnt_q;
		wdata = en_s1 ? upd : ent_t'{left: BND_W'(COLS), right: '0};
		raddr = cmd.walk_step ? ROW_AW'(row_q) : ROW_AW'(qrow_q);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// Status
	always_comb begin
		sts.flat      = flat_q;
		sts.clr_last  = (clr_cnt_q == ROW_AW'(ROWS - 1));
		sts.div_last  = (div_cnt_q == DIV_CW'(NUM_W - 1));
		sts.walk_last = (({1'b0, row_q} + 1'b1) == {1'b0, yb_q});
	end

	// Query result; rows beyond the table read as an empty span
	logic             q_rng;
	logic [BND_W-1:0] q_left, q_right;

	always_comb begin
		q_rng             = ({1'b0, qrow_q} < ROWS);
		q_left            = q_rng ? rd_q.left  : BND_W'(COLS);
		q_right           = q_rng ? rd_q.right : '0;
		res.row_index     = qrow_q;
		res.span_left     = q_left[COORD_W-1:0];
		res.span_right    = q_right[COORD_W-1:0];
		res.span_nonempty = (q_left < q_right);
	end

endmodule

// File: sv/scanline_span_table_fill.sv
// Scan-line span tables: a left and a right bound for each of ROWS rows.
// Request channel: a word on req is taken at a rising edge with start high
// and busy low. req_type selects clear, add edge or query; other codes are
// taken and dropped.
// Result channel: a query gives one word on res, marked by done for a single
// cycle; the receiver cannot stall it, so it must take it then.
// Steps, from the accepting edge until busy falls:
//   clear      one table row written per cycle, over all ROWS rows
//   add edge   a setup step, which ends the request for a horizontal edge;
//              else the one-bit-per-cycle slope divider for NUM_W (22) bits,
//              a slope load, dy walk steps (one row per cycle through the
//              table's read and write ports) and a drain step for the write
//   query      a read state, then an output state: done high, res holds the span
// One request is in work at a time. The next word can be taken in the
// first cycle in which busy is low.
// After reset the block clears both tables itself: busy stays high until
// all ROWS (512) rows are cleared, and only then is the first request taken.
module scanline_span_table_fill (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sstf_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output sstf_pkg::res_t res
);
	import sstf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sstf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	sstf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

// File: sv/sstf_chk.sv
module sstf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input sstf_pkg::req_t req,
	input sstf_pkg::res_t res
);
	import sstf_pkg::*;

	// A query word is answered by done once its read state has passed
	a_query_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.req_type == REQ_QUERY)) |-> ##2 done)
		else $error("query not answered in two cycles");

	// A result only shows while a request is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result outside a request");

	// One word per query
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

	// A clear holds the request channel off
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req.req_type == REQ_CLEAR)) |=> busy)
		else $error("clear did not hold off requests");

endmodule

bind scanline_span_table_fill sstf_chk u_chk (.*);
